/* rtl/bls_pkg.sv */
package bls_pkg;

  // built depth and field widths
  localparam int unsigned BlsDepth = 16;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CapW     = 5;
  localparam int unsigned LevelW   = 5;

  // capacity after reset
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // fixed result words
  localparam logic signed [WordW-1:0] WordMin      = 32'sh8000_0000;
  localparam logic signed [WordW-1:0] WordNotFound = -32'sd1;
  localparam logic signed [WordW-1:0] WordZero     = 32'sd0;

  // request codes
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_NOTFOUND  = 2'd3
  } status_e;

  // control states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  // request beat
  typedef struct packed {
    mode_e                   mode;
    logic signed [WordW-1:0] data_in;
  } bls_in_t;

  // result beat
  typedef struct packed {
    logic signed [WordW-1:0] data_out;
    status_e                 status;
    logic [LevelW-1:0]       level;
  } bls_out_t;

  // shift control shared by every cell
  typedef struct packed {
    logic load_above;  // push: take the word from the cell nearer the top
    logic load_below;  // pop or scan: take the word from the cell below
  } bls_cell_op_t;

endpackage

/* rtl/bls_cell.sv */
module bls_cell
  import bls_pkg::*;
(
  input  logic                    clk_i,
  input  bls_cell_op_t            op_i,
  input  logic signed [WordW-1:0] above_i,
  input  logic signed [WordW-1:0] below_i,
  output logic signed [WordW-1:0] word_o
);

  logic signed [WordW-1:0] word_q;

  // one stack slot, shifts toward the bottom on push, toward the top on pop
  always_ff @(posedge clk_i) begin
    if (op_i.load_above) begin
      word_q <= above_i;
    end else if (op_i.load_below) begin
      word_q <= below_i;
    end
  end

  assign word_o = word_q;

endmodule

/* rtl/bounded_lifo_stack_with_search.sv */
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    in_data_i  (bls_in_t: mode, data_in)
// out       output     out_valid_o / out_stall_i  out_data_o (bls_out_t: data_out, status, level)
// cfg       input      cfg_we_i                   cfg_wdata_i (capacity)
//
// push, pop and peek finish on the accept; their result beat is registered into the output queue
// search: once accepted, the input stalls for DEPTH steps in which
// the cell chain rotates once around with the top cell compared against the key
// the input stalls during a scan and while the skid slot holds a beat
// reset clears the fill count, the state and the output queue; cells hold no reset
// a two-deep output queue lets one beat be accepted while a result waits

module bounded_lifo_stack_with_search
  import bls_pkg::*;
#(
  parameter int unsigned DEPTH = BlsDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bls_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bls_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = (CW > CapW) ? CW : CapW;
  localparam logic [LW-1:0] DepthL = LW'(DEPTH);
  localparam logic [IW-1:0] ScanLast = IW'(DEPTH - 1);

  logic [CapW-1:0]         cap_q;
  logic [CW-1:0]           count_q, count_d;
  state_e                  state_q, state_d;
  logic [IW-1:0]           scan_cnt_q, scan_cnt_d;
  logic signed [WordW-1:0] key_q;
  logic                    hit_q, hit_d;
  logic                    out_valid_q, skid_valid_q;
  bls_out_t                out_q, skid_q;

  logic                    in_fire, take;
  logic                    full, empty, scan_hit;
  logic [LW-1:0]           cap_ext, cap_use, count_ext;
  logic                    res_valid, start_scan;
  bls_out_t                res;
  bls_cell_op_t            op;
  logic signed [WordW-1:0] cell_word [DEPTH];

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // capacity clamped to 1..DEPTH
  assign cap_ext   = LW'(cap_q);
  assign count_ext = LW'(count_q);
  always_comb begin
    if (cap_ext == '0) begin
      cap_use = LW'(1);
    end else if (cap_ext > DepthL) begin
      cap_use = DepthL;
    end else begin
      cap_use = cap_ext;
    end
  end
  assign full  = (count_ext >= cap_use);
  assign empty = (count_q == '0);

  assign in_stall_o = (state_q != S_IDLE) || skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign take       = out_valid_q && !out_stall_i;

  // top cell holds the entry being compared in this scan cycle
  assign scan_hit = (CW'(scan_cnt_q) < count_q) && (cell_word[0] == key_q);

  // request decode and result forming
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_cnt_d   = scan_cnt_q;
    hit_d        = hit_q;
    op           = '0;
    res_valid    = 1'b0;
    start_scan   = 1'b0;
    res.data_out = WordZero;
    res.status   = STAT_OK;
    res.level    = LevelW'(count_q);
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.mode)
            MODE_PUSH: begin
              res_valid = 1'b1;
              if (full) begin
                res.status = STAT_OVERFLOW;
              end else begin
                op.load_above = 1'b1;
                count_d       = count_q + CW'(1);
              end
            end
            MODE_POP: begin
              res_valid = 1'b1;
              if (empty) begin
                res.data_out = WordMin;
                res.status   = STAT_UNDERFLOW;
              end else begin
                res.data_out  = cell_word[0];
                op.load_below = 1'b1;
                count_d       = count_q - CW'(1);
              end
            end
            MODE_PEEK: begin
              res_valid = 1'b1;
              if (empty) begin
                res.data_out = WordMin;
                res.status   = STAT_UNDERFLOW;
              end else begin
                res.data_out = cell_word[0];
              end
            end
            MODE_SEARCH: begin
              start_scan = 1'b1;
              scan_cnt_d = '0;
              hit_d      = 1'b0;
              state_d    = S_SCAN;
            end
            default: ;
          endcase
          res.level = LevelW'(count_d);
        end
      end
      S_SCAN: begin
        op.load_below = 1'b1;
        hit_d         = hit_q || scan_hit;
        scan_cnt_d    = scan_cnt_q + IW'(1);
        if (scan_cnt_q == ScanLast) begin
          res_valid = 1'b1;
          state_d   = S_IDLE;
          if (hit_d) begin
            res.data_out = key_q;
            res.status   = STAT_OK;
          end else begin
            res.data_out = WordNotFound;
            res.status   = STAT_NOTFOUND;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      scan_cnt_q <= '0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      scan_cnt_q <= scan_cnt_d;
      hit_q      <= hit_d;
    end
  end

  // search key
  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      key_q <= in_data_i.data_in;
    end
  end

  // chain of cells, cell 0 is the top, the bottom wraps to the top for the scan
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WordW-1:0] above, below;
    if (g == 0) begin : g_top
      assign above = in_data_i.data_in;
    end else begin : g_mid
      assign above = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_bot
      assign below = cell_word[0];
    end else begin : g_up
      assign below = cell_word[g+1];
    end
    bls_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .word_o  (cell_word[g])
    );
  end

  // two-deep result queue: output register and skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= res_valid;
      end else begin
        out_valid_q  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= res;
      end else begin
        out_q  <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // fill never passes the built depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(count_q) <= CW'(DEPTH))
    else $error("fill count above depth");

  // no beat is taken while the chain rotates
  a_scan_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> in_stall_o)
    else $error("input accepted during scan");

  // skid slot only fills behind a held output beat
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat with output empty");

  // scan leaves the fill alone
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (count_q == $past(count_q)))
    else $error("fill changed during scan");

  // a scan starts from the top cell
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_scan |=> (scan_cnt_q == '0) && (state_q == S_SCAN))
    else $error("scan did not start at the top");

endmodule
